/* rtl/hhls_pkg.sv */
`timescale 1ns / 1ps

package hhls_pkg;

	// Field widths of the result item
	localparam int HDR_W     = 17;
	localparam int BODY_W    = 31;
	localparam int OUTCOME_W = 2;

	// Scanner widths
	localparam int NAME_LEN = 14;
	localparam int PROG_W   = 4;
	localparam int TERM_W   = 3;
	localparam int PHASE_W  = 2;

	// Largest value magnitude; longer digit strings saturate here
	localparam logic [BODY_W-1:0] VALUE_MAX = 31'h7FFF_FFFF;

	// Outcome codes
	localparam logic [OUTCOME_W-1:0] OUTCOME_OK       = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUTCOME_NO_TERM  = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUTCOME_NEGATIVE = 2'd2;

	// Value parser phases
	localparam logic [PHASE_W-1:0] PHASE_SKIP   = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_DIGITS = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_DONE   = 2'd2;

	// Blank-line terminator progress
	localparam logic [TERM_W-1:0] TERM_NONE = 3'd0;
	localparam logic [TERM_W-1:0] TERM_CR1  = 3'd1;
	localparam logic [TERM_W-1:0] TERM_LF1  = 3'd2;
	localparam logic [TERM_W-1:0] TERM_CR2  = 3'd3;
	localparam logic [TERM_W-1:0] TERM_LF2  = 3'd4;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_VT    = 8'd11;
	localparam logic [7:0] CH_FF    = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_GAP = 8'd32;

	// Result of the scan of one buffer
	typedef struct packed {
		logic                 done;
		logic [HDR_W-1:0]     header_bytes;
		logic [BODY_W-1:0]    body_bytes;
		logic [OUTCOME_W-1:0] outcome;
	} scan_res_t;

	// Lower-case header name, one character per match position
	function automatic logic [7:0] name_char(input logic [PROG_W-1:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = "c";
			4'd1:    ch = "o";
			4'd2:    ch = "n";
			4'd3:    ch = "t";
			4'd4:    ch = "e";
			4'd5:    ch = "n";
			4'd6:    ch = "t";
			4'd7:    ch = "-";
			4'd8:    ch = "l";
			4'd9:    ch = "e";
			4'd10:   ch = "n";
			4'd11:   ch = "g";
			4'd12:   ch = "t";
			4'd13:   ch = "h";
			default: ch = 8'd0;
		endcase
		return ch;
	endfunction

endpackage

/* rtl/hhls_if.sv */
`timescale 1ns / 1ps

// Byte channel into the scanner
interface hhls_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source (output valid, output data_byte, output end_of_buffer, input ready);
	modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// Result channel out of the scanner
interface hhls_out_if;
	logic                           valid;
	logic                           ready;
	logic [hhls_pkg::HDR_W-1:0]     header_bytes;
	logic [hhls_pkg::BODY_W-1:0]    body_bytes;
	logic [hhls_pkg::OUTCOME_W-1:0] outcome;

	modport source (output valid, output header_bytes, output body_bytes, output outcome,
		input ready);
	modport sink   (input valid, input header_bytes, input body_bytes, input outcome,
		output ready);
endinterface

/* rtl/hhls_scan.sv */
`timescale 1ns / 1ps

module hhls_scan #(
	parameter int BUFFER_BYTES = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                end_of_buffer,
	output hhls_pkg::scan_res_t res
);

	localparam int POS_W = $clog2(BUFFER_BYTES + 1);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(BUFFER_BYTES);
	localparam logic [hhls_pkg::PROG_W-1:0] NAME_END = hhls_pkg::PROG_W'(hhls_pkg::NAME_LEN);

	logic [POS_W-1:0]                 pos_q, pos_n;
	logic [hhls_pkg::TERM_W-1:0]      term_q, term_n;
	logic [hhls_pkg::PROG_W-1:0]      prog_q, prog_n;
	logic                             has_name_q, has_name_n;
	logic                             colon_q, colon_n;
	logic [hhls_pkg::PHASE_W-1:0]     phase_q, phase_n;
	logic                             neg_q, neg_n;
	logic [hhls_pkg::BODY_W-1:0]      acc_q, acc_n;
	logic                             found_q, found_n;
	logic                             found_neg_q, found_neg_n;
	logic [hhls_pkg::BODY_W-1:0]      found_mag_q, found_mag_n;
	logic                             finished_q;

	logic                             is_cr, is_lf, is_eol, is_nul, is_blank, is_digit;
	logic [7:0]                       lc;
	logic [3:0]                       digit_val;
	logic [hhls_pkg::BODY_W+3:0]      acc_next_wide;
	logic [hhls_pkg::BODY_W-1:0]      acc_step;
	logic [hhls_pkg::HDR_W+POS_W-1:0] hdr_ext;
	logic                             done;

	// Classify the byte
	always_comb begin
		is_cr     = (data_byte == hhls_pkg::CH_CR);
		is_lf     = (data_byte == hhls_pkg::CH_LF);
		is_eol    = is_cr || is_lf;
		is_nul    = (data_byte == hhls_pkg::CH_NUL);
		is_blank  = (data_byte == hhls_pkg::CH_SPACE) || (data_byte == hhls_pkg::CH_TAB) ||
			(data_byte == hhls_pkg::CH_VT) || (data_byte == hhls_pkg::CH_FF);
		is_digit  = (data_byte >= hhls_pkg::CH_ZERO) && (data_byte <= hhls_pkg::CH_NINE);
		digit_val = 4'(data_byte - hhls_pkg::CH_ZERO);
		lc        = ((data_byte >= hhls_pkg::CH_UP_A) && (data_byte <= hhls_pkg::CH_UP_Z)) ?
			data_byte + hhls_pkg::CASE_GAP : data_byte;
	end

	// Multiply by ten and add the digit, saturating
	always_comb begin
		acc_next_wide = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
			{{(hhls_pkg::BODY_W){1'b0}}, digit_val};
		acc_step = (acc_next_wide > {4'b0000, hhls_pkg::VALUE_MAX}) ?
			hhls_pkg::VALUE_MAX : acc_next_wide[hhls_pkg::BODY_W-1:0];
	end

	// Next scan state for this byte
	always_comb begin
		pos_n       = (pos_q != POS_LIMIT) ? pos_q + POS_W'(1) : pos_q;
		prog_n      = prog_q;
		has_name_n  = has_name_q;
		colon_n     = colon_q;
		phase_n     = phase_q;
		neg_n       = neg_q;
		acc_n       = acc_q;
		found_n     = found_q;
		found_neg_n = found_neg_q;
		found_mag_n = found_mag_q;

		if (is_eol) begin
			// Commit the first complete length line, then start a fresh line
			if (!found_q && has_name_q && colon_q) begin
				found_n     = 1'b1;
				found_neg_n = neg_q && (acc_q != '0);
				found_mag_n = acc_q;
			end
			prog_n     = '0;
			has_name_n = 1'b0;
			colon_n    = 1'b0;
			phase_n    = hhls_pkg::PHASE_SKIP;
			neg_n      = 1'b0;
			acc_n      = '0;
		end else begin
			// Advance the name search
			if (!has_name_q) begin
				if (prog_q < NAME_END && lc == hhls_pkg::name_char(prog_q)) begin
					prog_n = prog_q + hhls_pkg::PROG_W'(1);
				end else if (lc == hhls_pkg::name_char('0)) begin
					prog_n = hhls_pkg::PROG_W'(1);
				end else begin
					prog_n = '0;
				end
				has_name_n = (prog_n == NAME_END);
			end

			// Parse the value after the first colon
			if (colon_q) begin
				case (phase_q)
					hhls_pkg::PHASE_SKIP: begin
						if (data_byte == hhls_pkg::CH_PLUS) begin
							phase_n = hhls_pkg::PHASE_DIGITS;
						end else if (data_byte == hhls_pkg::CH_MINUS) begin
							phase_n = hhls_pkg::PHASE_DIGITS;
							neg_n   = 1'b1;
						end else if (is_digit) begin
							phase_n = hhls_pkg::PHASE_DIGITS;
							acc_n   = acc_step;
						end else if (!is_blank) begin
							phase_n = hhls_pkg::PHASE_DONE;
						end
					end
					hhls_pkg::PHASE_DIGITS: begin
						if (is_digit) begin
							acc_n = acc_step;
						end else begin
							phase_n = hhls_pkg::PHASE_DONE;
						end
					end
					default: phase_n = hhls_pkg::PHASE_DONE;
				endcase
			end else if (data_byte == hhls_pkg::CH_COLON) begin
				colon_n = 1'b1;
			end
		end

		// Track CR LF CR LF
		if (is_cr) begin
			term_n = (term_q == hhls_pkg::TERM_LF1) ? hhls_pkg::TERM_CR2 : hhls_pkg::TERM_CR1;
		end else if (is_lf) begin
			if (term_q == hhls_pkg::TERM_CR1) begin
				term_n = hhls_pkg::TERM_LF1;
			end else if (term_q == hhls_pkg::TERM_CR2) begin
				term_n = hhls_pkg::TERM_LF2;
			end else begin
				term_n = hhls_pkg::TERM_NONE;
			end
		end else begin
			term_n = hhls_pkg::TERM_NONE;
		end
	end

	// Form the result
	always_comb begin
		hdr_ext          = {{(hhls_pkg::HDR_W){1'b0}}, pos_n};
		res.header_bytes = '0;
		res.body_bytes   = '0;
		res.outcome      = hhls_pkg::OUTCOME_OK;
		done             = 1'b0;
		if (!finished_q) begin
			if (is_nul) begin
				done        = 1'b1;
				res.outcome = hhls_pkg::OUTCOME_NO_TERM;
			end else if (term_n == hhls_pkg::TERM_LF2) begin
				done = 1'b1;
				if (found_n && found_neg_n) begin
					res.outcome = hhls_pkg::OUTCOME_NEGATIVE;
				end else begin
					res.header_bytes = hdr_ext[hhls_pkg::HDR_W-1:0];
					res.body_bytes   = found_n ? found_mag_n : '0;
				end
			end else if (end_of_buffer || pos_n == POS_LIMIT) begin
				done        = 1'b1;
				res.outcome = hhls_pkg::OUTCOME_NO_TERM;
			end
		end
		res.done = done;
	end

	// Update the scan state; the last byte of a buffer clears everything
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			term_q      <= hhls_pkg::TERM_NONE;
			prog_q      <= '0;
			has_name_q  <= 1'b0;
			colon_q     <= 1'b0;
			phase_q     <= hhls_pkg::PHASE_SKIP;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			found_q     <= 1'b0;
			found_neg_q <= 1'b0;
			found_mag_q <= '0;
			finished_q  <= 1'b0;
		end else if (step) begin
			if (end_of_buffer) begin
				pos_q       <= '0;
				term_q      <= hhls_pkg::TERM_NONE;
				prog_q      <= '0;
				has_name_q  <= 1'b0;
				colon_q     <= 1'b0;
				phase_q     <= hhls_pkg::PHASE_SKIP;
				neg_q       <= 1'b0;
				acc_q       <= '0;
				found_q     <= 1'b0;
				found_neg_q <= 1'b0;
				found_mag_q <= '0;
				finished_q  <= 1'b0;
			end else if (!finished_q) begin
				pos_q       <= pos_n;
				term_q      <= term_n;
				prog_q      <= prog_n;
				has_name_q  <= has_name_n;
				colon_q     <= colon_n;
				phase_q     <= phase_n;
				neg_q       <= neg_n;
				acc_q       <= acc_n;
				found_q     <= found_n;
				found_neg_q <= found_neg_n;
				found_mag_q <= found_mag_n;
				finished_q  <= done;
			end
		end
	end

endmodule

/* rtl/http_header_length_scanner_core.sv */
`timescale 1ns / 1ps

// HTTP response header length scanner. Bytes of a response arrive one per
// transfer on the byte channel, the last byte of each buffer marked; the block
// finds the first CR LF CR LF and reports the header length, the value of the
// first Content-Length line (name matched case-insensitively, value parsed
// after the first colon, saturating at 2^31-1) and an outcome code. One
// result is given per buffer; bytes after the result are dropped until the
// end mark. The block takes one byte every cycle while no held result stalls
// it: a byte is captured in the input register, and when it is processed the
// scan state and the multiply-by-ten accumulator update and the result is
// loaded into the output register, from which it is offered. The byte channel
// stalls only while a held result waits on the result channel.
module http_header_length_scanner_core #(
	parameter int BUFFER_BYTES = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	hhls_in_if.sink           bytes,
	hhls_out_if.source        result
);

	logic                           valid_s1;
	logic [7:0]                     data_s1;
	logic                           last_s1;
	logic                           out_valid_q;
	logic [hhls_pkg::HDR_W-1:0]     header_q;
	logic [hhls_pkg::BODY_W-1:0]    body_q;
	logic [hhls_pkg::OUTCOME_W-1:0] outcome_q;
	logic                           out_free;
	logic                           advance;
	hhls_pkg::scan_res_t            scan_res;

	// Process the held byte once the result slot can take an answer
	assign out_free    = !out_valid_q || result.ready;
	assign advance     = valid_s1 && out_free;
	assign bytes.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			data_s1 <= bytes.data_byte;
			last_s1 <= bytes.end_of_buffer;
		end
	end

	hhls_scan #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.data_byte     (data_s1),
		.end_of_buffer (last_s1),
		.res           (scan_res)
	);

	// Result register: load a finished scan, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && scan_res.done) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && scan_res.done) begin
			header_q  <= scan_res.header_bytes;
			body_q    <= scan_res.body_bytes;
			outcome_q <= scan_res.outcome;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.header_bytes = header_q;
	assign result.body_bytes   = body_q;
	assign result.outcome      = outcome_q;

	// A new result only follows a processed byte
	a_result_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance))
		else $error("result raised without a processed byte");

	// Failed scans report zero lengths
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && outcome_q != hhls_pkg::OUTCOME_OK) |->
			(header_q == '0 && body_q == '0))
		else $error("nonzero length on a failed scan");

	// A held byte stays put while the result slot is blocked
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(data_s1) && $stable(last_s1)))
		else $error("held byte lost while stalled");

	// A successful scan never reports a header shorter than the terminator
	a_ok_header: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && outcome_q == hhls_pkg::OUTCOME_OK && BUFFER_BYTES < 131072) |->
			(header_q >= hhls_pkg::HDR_W'(4)))
		else $error("header length shorter than terminator");

endmodule

/* tb/http_header_length_scanner_core_tb.sv */
`timescale 1ns / 1ps

module http_header_length_scanner_core_tb;

	localparam int BUFFER_LIMIT   = 128;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int REPORT_LIMIT   = 10;
	localparam int HOLD_CYCLES    = 300;

	// Header name in lower case, first character in the top byte
	localparam logic [8*hhls_pkg::NAME_LEN-1:0] NAME_TEXT = "content-length";

	typedef struct packed {
		logic [hhls_pkg::HDR_W-1:0]     header_bytes;
		logic [hhls_pkg::BODY_W-1:0]    body_bytes;
		logic [hhls_pkg::OUTCOME_W-1:0] outcome;
	} scan_report_t;

	logic clk;
	logic arst_n;

	hhls_in_if  byte_if ();
	hhls_out_if res_if ();

	http_header_length_scanner_core #(
		.BUFFER_BYTES(BUFFER_LIMIT)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_if),
		.result (res_if)
	);

	// Scan state of the predictor
	logic [31:0]                  scan_pos;
	logic [hhls_pkg::TERM_W-1:0]  term_state;
	logic [hhls_pkg::PROG_W-1:0]  name_pos;
	logic                         line_named;
	logic                         line_colon;
	logic [hhls_pkg::PHASE_W-1:0] value_stage;
	logic                         value_minus;
	logic [31:0]                  value_mag;
	logic [31:0]                  held_length;
	logic                         length_held;
	logic                         scan_over;

	scan_report_t expected_reports[$];
	logic [7:0]   pending_bytes[$];

	int mismatch_count  = 0;
	int bytes_sent      = 0;
	int idle_cycles     = 0;
	int result_hold_len = 0;
	bit source_gaps     = 1'b1;
	bit sink_gaps       = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] name_letter(input int idx);
		return NAME_TEXT[8*(hhls_pkg::NAME_LEN-1-idx) +: 8];
	endfunction

	task automatic clear_header_line();
		name_pos    = '0;
		line_named  = 1'b0;
		line_colon  = 1'b0;
		value_stage = hhls_pkg::PHASE_SKIP;
		value_minus = 1'b0;
		value_mag   = '0;
	endtask

	task automatic clear_scan_state();
		scan_pos    = '0;
		term_state  = hhls_pkg::TERM_NONE;
		clear_header_line();
		held_length = '0;
		length_held = 1'b0;
		scan_over   = 1'b0;
	endtask

	// Advance the scan by one accepted byte and queue the report it gives
	task automatic scan_header_byte(input logic [7:0] ch, input logic last);
		logic [7:0]   folded;
		logic         digit;
		logic         take_digit;
		logic         finished;
		logic [63:0]  scaled;
		scan_report_t rpt;
		finished   = 1'b0;
		take_digit = 1'b0;
		rpt        = '0;
		if (!scan_over) begin
			if (scan_pos < BUFFER_LIMIT)
				scan_pos = scan_pos + 1;
			if (ch == hhls_pkg::CH_NUL) begin
				rpt.outcome = hhls_pkg::OUTCOME_NO_TERM;
				finished    = 1'b1;
			end else begin
				if (ch == hhls_pkg::CH_CR || ch == hhls_pkg::CH_LF) begin
					// line end: commit the first named line with a colon
					if (!length_held && line_named && line_colon) begin
						held_length = value_minus ? (32'd0 - value_mag) : value_mag;
						length_held = 1'b1;
					end
					clear_header_line();
				end else begin
					folded = (ch >= hhls_pkg::CH_UP_A && ch <= hhls_pkg::CH_UP_Z) ?
						ch + hhls_pkg::CASE_GAP : ch;
					if (!line_named) begin
						if (name_pos < hhls_pkg::NAME_LEN && folded == name_letter(name_pos))
							name_pos = name_pos + hhls_pkg::PROG_W'(1);
						else
							name_pos = (folded == name_letter(0)) ?
								hhls_pkg::PROG_W'(1) : '0;
						if (name_pos >= hhls_pkg::NAME_LEN)
							line_named = 1'b1;
					end
					if (line_colon) begin
						// value text: blanks, optional sign, then digits
						digit = (ch >= hhls_pkg::CH_ZERO && ch <= hhls_pkg::CH_NINE);
						if (value_stage == hhls_pkg::PHASE_SKIP) begin
							if (!(ch == hhls_pkg::CH_SPACE || ch == hhls_pkg::CH_TAB ||
								ch == hhls_pkg::CH_VT || ch == hhls_pkg::CH_FF)) begin
								if (ch == hhls_pkg::CH_PLUS) begin
									value_stage = hhls_pkg::PHASE_DIGITS;
								end else if (ch == hhls_pkg::CH_MINUS) begin
									value_minus = 1'b1;
									value_stage = hhls_pkg::PHASE_DIGITS;
								end else begin
									value_stage = digit ? hhls_pkg::PHASE_DIGITS
										: hhls_pkg::PHASE_DONE;
									take_digit  = digit;
								end
							end
						end else if (value_stage == hhls_pkg::PHASE_DIGITS && digit) begin
							take_digit = 1'b1;
						end else begin
							value_stage = hhls_pkg::PHASE_DONE;
						end
						if (take_digit) begin
							scaled    = {32'd0, value_mag} * 64'd10 +
								{56'd0, (ch - hhls_pkg::CH_ZERO)};
							value_mag = (scaled > {33'd0, hhls_pkg::VALUE_MAX}) ?
								{1'b0, hhls_pkg::VALUE_MAX} : scaled[31:0];
						end
					end else if (ch == hhls_pkg::CH_COLON) begin
						line_colon = 1'b1;
					end
				end

				// track the blank-line terminator
				if (ch == hhls_pkg::CH_CR)
					term_state = (term_state == hhls_pkg::TERM_LF1) ? hhls_pkg::TERM_CR2
						: hhls_pkg::TERM_CR1;
				else if (ch == hhls_pkg::CH_LF)
					term_state = (term_state == hhls_pkg::TERM_CR1) ? hhls_pkg::TERM_LF1 :
						(term_state == hhls_pkg::TERM_CR2) ? hhls_pkg::TERM_LF2 :
						hhls_pkg::TERM_NONE;
				else
					term_state = hhls_pkg::TERM_NONE;

				if (term_state == hhls_pkg::TERM_LF2) begin
					finished = 1'b1;
					if (length_held && held_length[31]) begin
						rpt.outcome = hhls_pkg::OUTCOME_NEGATIVE;
					end else begin
						rpt.outcome      = hhls_pkg::OUTCOME_OK;
						rpt.header_bytes = scan_pos[hhls_pkg::HDR_W-1:0];
						rpt.body_bytes   = length_held ?
							held_length[hhls_pkg::BODY_W-1:0] : '0;
					end
				end else if (last || scan_pos >= BUFFER_LIMIT) begin
					rpt.outcome = hhls_pkg::OUTCOME_NO_TERM;
					finished    = 1'b1;
				end
			end
			if (finished) begin
				scan_over = 1'b1;
				expected_reports.push_back(rpt);
			end
		end
		if (last)
			clear_scan_state();
	endtask

	// Offer one byte, with an optional idle burst, and wait for its transfer
	task automatic send_byte(input logic [7:0] value, input logic last);
		@(negedge clk);
		if (source_gaps && $urandom_range(0, 5) == 0) begin
			byte_if.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		byte_if.valid         <= 1'b1;
		byte_if.data_byte     <= value;
		byte_if.end_of_buffer <= last;
		@(posedge clk);
		while (!byte_if.ready)
			@(posedge clk);
		scan_header_byte(value, last);
		bytes_sent++;
	endtask

	// Drop valid and hold off until every report has arrived
	task automatic wait_drained();
		@(negedge clk);
		byte_if.valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			pending_bytes.push_back(s[i]);
	endtask

	task automatic add_random_bytes(input int count, input int lo, input int hi);
		logic [7:0] ch;
		repeat (count) begin
			ch = 8'($urandom_range(hi, lo));
			pending_bytes.push_back(ch);
		end
	endtask

	// Send the pending bytes as one buffer, end mark on the last
	task automatic flush_buffer();
		for (int i = 0; i < pending_bytes.size(); i++)
			send_byte(pending_bytes[i], i == pending_bytes.size() - 1);
		pending_bytes.delete();
	endtask

	// Build one response: mostly well-formed, some noise, cut short or with a zero byte
	task automatic queue_random_response();
		int         kind;
		int         lines;
		int         count;
		int         cut;
		logic [7:0] ch;
		kind = $urandom_range(0, 11);
		if (kind == 8) begin
			add_random_bytes($urandom_range(1, 12), 0, 255);
		end else begin
			if ($urandom_range(0, 1))
				add_text("HTTP/1.1 200 OK\015\n");
			lines = $urandom_range(0, 3);
			for (int l = 0; l < lines; l++) begin
				case ($urandom_range(0, 4))
					0, 1: begin
						if ($urandom_range(0, 3) == 0)
							add_text("X-");
						for (int i = 0; i < hhls_pkg::NAME_LEN; i++) begin
							ch = name_letter(i);
							if (ch != hhls_pkg::CH_MINUS && $urandom_range(0, 1))
								ch = ch - hhls_pkg::CASE_GAP;
							pending_bytes.push_back(ch);
						end
						if ($urandom_range(0, 7) != 0)
							pending_bytes.push_back(hhls_pkg::CH_COLON);
						repeat ($urandom_range(0, 2)) begin
							case ($urandom_range(0, 3))
								0:       pending_bytes.push_back(hhls_pkg::CH_SPACE);
								1:       pending_bytes.push_back(hhls_pkg::CH_TAB);
								2:       pending_bytes.push_back(hhls_pkg::CH_VT);
								default: pending_bytes.push_back(hhls_pkg::CH_FF);
							endcase
						end
						case ($urandom_range(0, 3))
							1:       pending_bytes.push_back(hhls_pkg::CH_PLUS);
							2:       pending_bytes.push_back(hhls_pkg::CH_MINUS);
							default: ;
						endcase
						count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12)
							: $urandom_range(1, 4);
						repeat (count) begin
							ch = 8'($urandom_range(hhls_pkg::CH_NINE, hhls_pkg::CH_ZERO));
							pending_bytes.push_back(ch);
						end
						if ($urandom_range(0, 3) == 0)
							add_random_bytes($urandom_range(1, 3), 32, 126);
					end
					2:       add_random_bytes($urandom_range(1, 10), 14, 255);
					3:       add_text("Server: test");
					default: add_text("Content-Len: 5");
				endcase
				case ($urandom_range(0, 5))
					4:       pending_bytes.push_back(hhls_pkg::CH_LF);
					5:       pending_bytes.push_back(hhls_pkg::CH_CR);
					default: add_text("\015\n");
				endcase
			end
			add_text("\015\n\015\n");
			add_random_bytes($urandom_range(0, 8), 0, 255);
			if (kind == 9) begin
				cut = $urandom_range(1, pending_bytes.size());
				while (pending_bytes.size() > cut)
					ch = pending_bytes.pop_back();
			end else if (kind == 10) begin
				pending_bytes[$urandom_range(0, pending_bytes.size() - 1)] = hhls_pkg::CH_NUL;
			end
		end
	endtask

	task automatic test_header_lengths();
		add_text("\015\n\015\n");
		flush_buffer();
		add_text("HTTP/1.1 200 OK\015\nContent-Length: 42\015\n\015\nab");
		pending_bytes.push_back(8'hFF);
		pending_bytes.push_back(8'h80);
		flush_buffer();
		add_text("\n\n\015\015\n\015\nXYZ");
		flush_buffer();
	endtask

	task automatic test_length_values();
		add_text("content-length:\t\013\014 +17x\015\n\015\n");
		flush_buffer();
		add_text("X-CONTENT-LENGTH: 2147483647\015\n\015\n");
		flush_buffer();
		add_text("Content-Length: 99999999999\015\n\015\n");
		flush_buffer();
		add_text("Content-Length: -5\015\n\015\n");
		flush_buffer();
		add_text("Content-Length: -0\015\n\015\n");
		flush_buffer();
		add_text("Content-Length:  - 3\015\n\015\n");
		flush_buffer();
		add_text("Content-Length: 12 34\015\n\015\n");
		flush_buffer();
		add_text("Content-Length: abc\015\nContent-Length: 9\015\n\015\n");
		flush_buffer();
	endtask

	task automatic test_line_rules();
		add_text("Content-Length 7\nContent-Length: 8\015\n\015\n");
		flush_buffer();
		add_text("xcontcontent-length:3\015foo\015\n\015\n");
		flush_buffer();
		add_text("a:content-length 5\015\n\015\n");
		flush_buffer();
		add_text("Content-Length: 6\015\n\015");
		flush_buffer();
	endtask

	task automatic test_scan_errors();
		// zero byte ends the scan, the rest of the buffer is dropped
		add_text("Conte");
		pending_bytes.push_back(hhls_pkg::CH_NUL);
		add_text("x\015\n\015\n");
		flush_buffer();
		pending_bytes.push_back(hhls_pkg::CH_NUL);
		flush_buffer();
		add_text("abc\015\n\015");
		flush_buffer();
		pending_bytes.push_back(8'hFF);
		flush_buffer();
	endtask

	// Stall the result side for a long stretch while the sender keeps offering
	task automatic test_result_backpressure();
		result_hold_len = HOLD_CYCLES;
		repeat (12) begin
			add_text("\015\n\015\n");
			flush_buffer();
		end
		wait_drained();
	endtask

	task automatic test_random_responses(input int byte_target, input bit with_idling);
		int start;
		bit idle_now;
		start = bytes_sent;
		while (bytes_sent - start < byte_target) begin
			idle_now    = with_idling && ($urandom_range(0, 3) != 0);
			source_gaps = idle_now;
			sink_gaps   = idle_now;
			queue_random_response();
			flush_buffer();
		end
	endtask

	// Largest header, then a buffer cut off by the byte limit
	task automatic test_buffer_limit();
		logic [7:0] filler;
		source_gaps = 1'b0;
		sink_gaps   = 1'b0;
		repeat (BUFFER_LIMIT - 4) begin
			filler = 8'($urandom_range(255, 14));
			send_byte(filler, 1'b0);
		end
		add_text("\015\n\015\n");
		flush_buffer();
		repeat (BUFFER_LIMIT) begin
			filler = 8'($urandom_range(255, 14));
			send_byte(filler, 1'b0);
		end
		add_text("ab");
		flush_buffer();
	endtask

	initial begin
		arst_n                = 1'b0;
		byte_if.valid         = 1'b0;
		byte_if.data_byte     = '0;
		byte_if.end_of_buffer = 1'b0;
		clear_scan_state();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_header_lengths();
		test_length_values();
		test_line_rules();
		test_scan_errors();
		test_result_backpressure();
		test_random_responses(600, 1'b1);
		wait_drained();
		test_random_responses(350, 1'b1);
		test_buffer_limit();
		test_random_responses(250, 1'b0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_reports.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Result side: random stall bursts, and a long hold when one is requested
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (result_hold_len != 0) begin
				res_if.ready <= 1'b0;
				repeat (result_hold_len) @(negedge clk);
				result_hold_len = 0;
			end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(0, 15)) @(negedge clk);
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Compare each result transfer with the oldest predicted report
	always @(posedge clk) begin : result_check
		scan_report_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_reports.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result: header=%0d body=%0d outcome=%0d",
						res_if.header_bytes, res_if.body_bytes, res_if.outcome);
			end else begin
				want = expected_reports.pop_front();
				if (res_if.header_bytes !== want.header_bytes ||
					res_if.body_bytes !== want.body_bytes ||
					res_if.outcome !== want.outcome) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display({"mismatch: expected header=%0d body=%0d outcome=%0d,",
							" got header=%0d body=%0d outcome=%0d"},
							want.header_bytes, want.body_bytes, want.outcome,
							res_if.header_bytes, res_if.body_bytes, res_if.outcome);
				end
			end
		end
	end

	// End the run if no transfer happens on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule
